/* design/m3i_pkg.sv */
package m3i_pkg;

  localparam int unsigned ELEM_W    = 32;
  localparam int unsigned NUM_ELEM  = 9;
  localparam int unsigned COF_W     = 64;
  // Row-0 element times cofactor needs 96 bits; one more covers the sum of three.
  localparam int unsigned SUM_W     = 97;
  localparam int unsigned DIV_STEPS = 32;
  // Set-up stage, one stage per quotient bit, and the saturating stage.
  localparam int unsigned DIV_LAT   = DIV_STEPS + 2;
  // Products, cofactors, partial products, product join, sum, rounding.
  localparam int unsigned FRONT_LAT = 6;
  localparam int unsigned IN_W      = ELEM_W * NUM_ELEM;
  localparam int unsigned OUT_W     = ELEM_W * (NUM_ELEM + 1);

  localparam logic signed [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic signed [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [COF_W-1:0]  cof_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef struct packed {
    logic                         singular;
    elem_t                        det;
    logic [NUM_ELEM-1:0][ELEM_W-1:0] inv;
  } result_t;

endpackage

/* design/m3i_div_lane.sv */
// Pipelined restoring divider for one inverse entry: rounds |cof| / |det| to
// nearest with ties away from zero, applies the sign and saturates.
module m3i_div_lane (
  input  logic           clk,
  input  logic           en,
  input  m3i_pkg::cof_t  cof,
  input  m3i_pkg::elem_t det,
  output m3i_pkg::elem_t inv
);

  localparam int unsigned W = m3i_pkg::ELEM_W;
  localparam int unsigned S = m3i_pkg::DIV_STEPS;

  logic [W-1:0]   rem_r [0:S];
  logic [W-1:0]   nlo_r [0:S];
  logic [W-1:0]   q_r   [0:S];
  logic [W-1:0]   ud_r  [0:S];
  logic           neg_r [0:S];
  logic           ovf_r [0:S];
  m3i_pkg::elem_t inv_r;

  logic [m3i_pkg::COF_W-1:0] uc;
  logic [W-1:0]              ud;
  logic [m3i_pkg::COF_W-1:0] num;

  always_comb begin
    uc  = cof[m3i_pkg::COF_W-1] ? (~cof + 1'b1) : cof;
    ud  = det[W-1] ? (~det + 1'b1) : det;
    num = uc + m3i_pkg::COF_W'(ud >> 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num[2*W-1:W];
      nlo_r[0] <= num[W-1:0];
      q_r[0]   <= '0;
      ud_r[0]  <= ud;
      neg_r[0] <= cof[m3i_pkg::COF_W-1] ^ det[W-1];
      // A quotient of 2^32 or more saturates whatever its sign.
      ovf_r[0] <= (num[2*W-1:W] >= ud);
    end
  end

  for (genvar k = 1; k <= S; k++) begin : g_step
    logic [W:0] trial;
    logic       ge;
    logic [W:0] diff;
    always_comb begin
      trial = {rem_r[k-1], nlo_r[k-1][W-1]};
      ge    = (trial >= {1'b0, ud_r[k-1]});
      diff  = trial - {1'b0, ud_r[k-1]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[W-1:0] : trial[W-1:0];
        nlo_r[k] <= {nlo_r[k-1][W-2:0], 1'b0};
        q_r[k]   <= {q_r[k-1][W-2:0], ge};
        ud_r[k]  <= ud_r[k-1];
        neg_r[k] <= neg_r[k-1];
        ovf_r[k] <= ovf_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (neg_r[S]) begin
        if (ovf_r[S] || q_r[S][W-1]) inv_r <= m3i_pkg::ELEM_MIN;
        else                          inv_r <= ~q_r[S] + 1'b1;
      end else begin
        if (ovf_r[S] || q_r[S][W-1]) inv_r <= m3i_pkg::ELEM_MAX;
        else                          inv_r <= q_r[S];
      end
    end
  end

  assign inv = inv_r;

endmodule

/* design/matrix3_inverse_top.sv */
// Channel  Direction  Beat contents
// in_      slave      tdata: m00, m01, m02, m10, m11, m12, m20, m21, m22 (32 bits each)
// out_     master     tdata: inv00 .. inv22, determinant (32 bits each); tuser: singular
//
// One matrix is accepted per cycle while in_tready is high. The pipeline is six stages
// of products, cofactors and determinant arithmetic followed by the restoring
// divider (one quotient bit per stage). The datapath holds no state between
// matrices; reset only clears the valid bits of the pipeline, output register and skid.
// A stall on out_tready fills the skid stage first, and only a full skid stage
// freezes the whole pipeline and drops in_tready, so no beat is lost or repeated.
module matrix3_inverse_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22 from the lowest bit up
  input  logic [m3i_pkg::IN_W-1:0]     in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22, determinant
  output logic [m3i_pkg::OUT_W-1:0]    out_tdata,
  // singular
  output logic                         out_tuser
);

  localparam int unsigned W      = m3i_pkg::ELEM_W;
  localparam int unsigned N      = m3i_pkg::NUM_ELEM;
  localparam int unsigned SH     = 2 * FRAC_BITS;
  localparam int unsigned LAT    = m3i_pkg::FRONT_LAT + m3i_pkg::DIV_LAT;
  localparam int unsigned RND_W  = m3i_pkg::SUM_W - SH;

  // The whole pipeline moves together; it only stops when the skid stage is full.
  logic en;
  logic skid_valid_r;
  logic out_valid_r;
  logic [LAT-1:0] vld_r;

  assign en        = !skid_valid_r;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  // Input elements in row-major order.
  m3i_pkg::elem_t e [0:N-1];
  for (genvar i = 0; i < N; i++) begin : g_elem
    assign e[i] = in_tdata[i*W +: W];
  end

  // Stage 1: the eighteen element products of the nine 2x2 cofactors.
  m3i_pkg::cof_t pa_r [0:N-1];
  m3i_pkg::cof_t pb_r [0:N-1];
  m3i_pkg::elem_t row0_s1_r [0:2];
  m3i_pkg::elem_t row0_s2_r [0:2];

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r[0] <= e[4] * e[8];  pb_r[0] <= e[7] * e[5];
      pa_r[1] <= e[2] * e[7];  pb_r[1] <= e[1] * e[8];
      pa_r[2] <= e[1] * e[5];  pb_r[2] <= e[2] * e[4];
      pa_r[3] <= e[5] * e[6];  pb_r[3] <= e[3] * e[8];
      pa_r[4] <= e[0] * e[8];  pb_r[4] <= e[2] * e[6];
      pa_r[5] <= e[3] * e[2];  pb_r[5] <= e[0] * e[5];
      pa_r[6] <= e[3] * e[7];  pb_r[6] <= e[6] * e[4];
      pa_r[7] <= e[6] * e[1];  pb_r[7] <= e[0] * e[7];
      pa_r[8] <= e[0] * e[4];  pb_r[8] <= e[3] * e[1];
      row0_s1_r <= e[0:2];
      row0_s2_r <= row0_s1_r;
    end
  end

  // Stage 2: cofactors. They are exact in 64 bits for every input pattern.
  // The copies that travel on keep them lined up with the rounded determinant.
  m3i_pkg::cof_t cof_r [0:4][0:N-1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N; i++) begin
        cof_r[0][i] <= pa_r[i] - pb_r[i];
      end
      for (int s = 1; s < 5; s++) begin
        cof_r[s] <= cof_r[s-1];
      end
    end
  end

  // Stage 3: each row-0 element times its cofactor, with the 64-bit cofactor
  // cut into a signed upper half and an unsigned lower half.
  logic signed [2*W-1:0] ph_r [0:2];
  logic signed [2*W:0]   pl_r [0:2];
  localparam int unsigned DCOL [0:2] = '{0, 3, 6};

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        ph_r[j] <= row0_s2_r[j] * $signed(cof_r[0][DCOL[j]][2*W-1:W]);
        pl_r[j] <= row0_s2_r[j] * $signed({1'b0, cof_r[0][DCOL[j]][W-1:0]});
      end
    end
  end

  // Stage 4: join the halves of each product; stage 5: sum the three terms.
  m3i_pkg::sum_t term_r [0:2];
  m3i_pkg::sum_t sum_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        term_r[j] <= (m3i_pkg::sum_t'(ph_r[j]) <<< W) + m3i_pkg::sum_t'(pl_r[j]);
      end
      sum_r <= term_r[0] + term_r[1] + term_r[2];
    end
  end

  // Stage 6: round half up to the element format and saturate.
  m3i_pkg::sum_t    sum_half;
  logic signed [RND_W-1:0] det_wide;
  m3i_pkg::elem_t   det_nxt;
  m3i_pkg::elem_t   det_r;

  always_comb begin
    sum_half = sum_r + (m3i_pkg::sum_t'(1) <<< (SH - 1));
    det_wide = RND_W'(sum_half >>> SH);
    if (det_wide[RND_W-1:W-1] == '0 || det_wide[RND_W-1:W-1] == '1) begin
      det_nxt = det_wide[W-1:0];
    end else if (det_wide[RND_W-1]) begin
      det_nxt = m3i_pkg::ELEM_MIN;
    end else begin
      det_nxt = m3i_pkg::ELEM_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det_r <= det_nxt;
    end
  end

  // Nine divider lanes; the determinant rides alongside them.
  m3i_pkg::elem_t inv [0:N-1];
  m3i_pkg::elem_t det_dly_r [0:m3i_pkg::DIV_LAT-1];

  for (genvar i = 0; i < N; i++) begin : g_lane
    m3i_div_lane u_lane (
      .clk (clk),
      .en  (en),
      .cof (cof_r[4][i]),
      .det (det_r),
      .inv (inv[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det_dly_r[0] <= det_r;
      for (int s = 1; s < m3i_pkg::DIV_LAT; s++) begin
        det_dly_r[s] <= det_dly_r[s-1];
      end
    end
  end

  // A zero determinant marks the matrix singular and clears every entry.
  m3i_pkg::result_t res_nxt;
  m3i_pkg::elem_t   det_end;

  always_comb begin
    det_end          = det_dly_r[m3i_pkg::DIV_LAT-1];
    res_nxt.det      = det_end;
    res_nxt.singular = (det_end == '0);
    for (int i = 0; i < N; i++) begin
      res_nxt.inv[i] = res_nxt.singular ? '0 : inv[i];
    end
  end

  // Output register with a skid stage behind it.
  m3i_pkg::result_t out_r;
  m3i_pkg::result_t skid_r;
  logic             out_fire;

  assign out_fire = out_valid_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (vld_r[LAT-1]) begin
      if (!out_valid_r || out_fire) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_r <= skid_r;
      end
    end else if (vld_r[LAT-1]) begin
      if (!out_valid_r || out_fire) begin
        out_r <= res_nxt;
      end else begin
        skid_r <= res_nxt;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.det, out_r.inv};
  assign out_tuser  = out_r.singular;

  // A full skid stage always sits behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a beat while the output register is empty");

  // A singular result carries a zero determinant and zero entries, and only then.
  a_singular_det: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == (out_tdata[N*W +: W] == '0)))
    else $error("singular flag disagrees with the determinant");

  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[N*W-1:0] == '0))
    else $error("singular result with nonzero inverse entries");

  // When the skid stage drains, the pipeline is free again on the next edge.
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_tready) |=> in_tready)
    else $error("pipeline still frozen after the skid stage drained");

endmodule

/* tb/matrix3_inverse_checker.sv */
`timescale 1ns / 100ps

// Watches both channels of the 3x3 inverse block, predicts each result from the
// accepted input beat and compares it with the next output beat, field by field.
module matrix3_inverse_checker #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  input  logic                      in_tready,
  input  logic [m3i_pkg::IN_W-1:0]  in_tdata,
  input  logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic [m3i_pkg::OUT_W-1:0] out_tdata,
  input  logic                      out_tuser,
  output int                        errors,
  output int                        pending
);

  typedef struct {
    logic [m3i_pkg::OUT_W-1:0] data;
    logic                      singular;
  } inv_result_t;

  inv_result_t expected_inverses[$];

  function automatic longint cofactor(input m3i_pkg::elem_t a, input m3i_pkg::elem_t b,
                                      input m3i_pkg::elem_t c, input m3i_pkg::elem_t d);
    longint p;
    longint q;
    p = longint'(a) * longint'(b);
    q = longint'(c) * longint'(d);
    return p - q;
  endfunction

  function automatic logic signed [127:0] wide_mul(input m3i_pkg::elem_t a,
                                                   input longint c);
    logic signed [127:0] ax;
    logic signed [127:0] cx;
    ax = a;
    cx = c;
    return ax * cx;
  endfunction

  function automatic longint divide_round(input longint c, input longint d);
    logic signed [127:0] cs;
    logic signed [127:0] ds;
    logic [127:0]        uc;
    logic [127:0]        ud;
    logic [127:0]        q;
    logic                neg;
    cs  = c;
    ds  = d;
    neg = (c < 0) != (d < 0);
    uc  = cs < 0 ? -cs : cs;
    ud  = ds < 0 ? -ds : ds;
    q   = (uc + (ud >> 1)) / ud;
    if (neg) begin
      if (q >= 128'h8000_0000) return -longint'(64'h8000_0000);
      return -longint'(q[63:0]);
    end
    if (q > 128'h7FFF_FFFF) return longint'(64'h7FFF_FFFF);
    return longint'(q[63:0]);
  endfunction

  function automatic inv_result_t predict_inverse(input logic [m3i_pkg::IN_W-1:0] m);
    m3i_pkg::elem_t      a[3][3];
    longint              cof[3][3];
    logic signed [127:0] s;
    logic signed [127:0] t;
    longint              d;
    longint              q;
    inv_result_t         r;
    for (int i = 0; i < 9; i++)
      a[i / 3][i % 3] = m[i*m3i_pkg::ELEM_W +: m3i_pkg::ELEM_W];
    cof[0][0] = cofactor(a[1][1], a[2][2], a[2][1], a[1][2]);
    cof[0][1] = cofactor(a[0][2], a[2][1], a[0][1], a[2][2]);
    cof[0][2] = cofactor(a[0][1], a[1][2], a[0][2], a[1][1]);
    cof[1][0] = cofactor(a[1][2], a[2][0], a[1][0], a[2][2]);
    cof[1][1] = cofactor(a[0][0], a[2][2], a[0][2], a[2][0]);
    cof[1][2] = cofactor(a[1][0], a[0][2], a[0][0], a[1][2]);
    cof[2][0] = cofactor(a[1][0], a[2][1], a[2][0], a[1][1]);
    cof[2][1] = cofactor(a[2][0], a[0][1], a[0][0], a[2][1]);
    cof[2][2] = cofactor(a[0][0], a[1][1], a[1][0], a[0][1]);
    s = wide_mul(a[0][0], cof[0][0]) + wide_mul(a[0][1], cof[1][0])
      + wide_mul(a[0][2], cof[2][0]);
    s = s + (128'sd1 <<< (2 * FRAC_BITS - 1));
    t = s >>> (2 * FRAC_BITS);
    if (t > 128'sh7FFF_FFFF) d = 64'h7FFF_FFFF;
    else if (t < -128'sh8000_0000) d = -longint'(64'h8000_0000);
    else d = longint'(t[63:0]);
    r.data = '0;
    for (int i = 0; i < 9; i++) begin
      q = d == 0 ? 64'd0 : divide_round(cof[i / 3][i % 3], d);
      r.data[i*m3i_pkg::ELEM_W +: m3i_pkg::ELEM_W] = q[m3i_pkg::ELEM_W-1:0];
    end
    r.data[9*m3i_pkg::ELEM_W +: m3i_pkg::ELEM_W] = d[31:0];
    r.singular = d == 0;
    return r;
  endfunction

  always @(posedge clk) begin
    inv_result_t want;
    int          bad;
    bad = 0;
    if (!rst_n) begin
      errors  <= 0;
      pending <= 0;
    end else begin
      if (in_tvalid && in_tready) expected_inverses.push_back(predict_inverse(in_tdata));
      if (out_tvalid && out_tready) begin
        if (expected_inverses.size() == 0) begin
          $display("%0t: result beat with nothing expected, got %h", $time, out_tdata);
          bad = bad + 1;
        end else begin
          want = expected_inverses.pop_front();
          for (int f = 0; f < 10; f++) begin
            if (out_tdata[f*m3i_pkg::ELEM_W +: m3i_pkg::ELEM_W]
                !== want.data[f*m3i_pkg::ELEM_W +: m3i_pkg::ELEM_W]) begin
              $display("%0t: field %0d expected %h actual %h", $time, f,
                       want.data[f*m3i_pkg::ELEM_W +: m3i_pkg::ELEM_W],
                       out_tdata[f*m3i_pkg::ELEM_W +: m3i_pkg::ELEM_W]);
              bad = bad + 1;
            end
          end
          if (out_tuser !== want.singular) begin
            $display("%0t: singular expected %b actual %b", $time, want.singular, out_tuser);
            bad = bad + 1;
          end
        end
      end
      errors  <= errors + bad;
      pending <= expected_inverses.size();
    end
  end
endmodule

/* tb/matrix3_inverse_top_tb.sv */
`timescale 1ns / 100ps

// Stimulus and verdict for the 3x3 inverse block; all checking sits in the checker.
module matrix3_inverse_top_tb;

  localparam int  NUM_RANDOM = 800;
  localparam int  CALM_TAIL  = 120;     // final beats sent with no idling at all
  localparam int  LIMIT      = 300000;
  localparam int  ONE        = 65536;   // 1.0 in Q16.16

  logic                       clk;
  logic                       rst_n;
  logic                       in_tvalid;
  logic                       in_tready;
  logic [m3i_pkg::IN_W-1:0]   in_tdata;
  logic                       out_tvalid;
  logic                       out_tready;
  logic [m3i_pkg::OUT_W-1:0]  out_tdata;
  logic                       out_tuser;
  int                         errors;
  int                         pending;
  int                         cycles = 0;
  logic                       in_taken;
  logic                       calm;

  matrix3_inverse_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  matrix3_inverse_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Records whether the last rising edge took an input beat, so that the driver,
  // working on falling edges, never races the handshake.
  always @(posedge clk) in_taken <= in_tvalid && in_tready;

  // Watchdog: a hung block must still give a verdict.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // The receiver stalls in random bursts, except in the calm tail.
  initial begin
    int n;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 13);
        out_tready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
        n = $urandom_range(1, 20);
        repeat (n - 1) begin
          @(negedge clk);
          if (calm) break;
        end
      end
    end
  end

  // A random element: full range, modest Q16.16, tiny, or a corner value.
  function automatic m3i_pkg::elem_t rand_elem(input int kind);
    m3i_pkg::elem_t corner[8];
    corner = '{m3i_pkg::ELEM_MAX, m3i_pkg::ELEM_MIN, 0, ONE, -ONE, 1, -1,
               m3i_pkg::ELEM_MAX - 1};
    case (kind)
      0: return $urandom;
      1: return $signed($urandom_range(0, 8 * ONE)) - 4 * ONE;
      2: return $signed($urandom_range(0, 1024)) - 512;
      default: return corner[$urandom_range(0, 7)];
    endcase
  endfunction

  function automatic logic [m3i_pkg::IN_W-1:0] pack_matrix(input m3i_pkg::elem_t e[9]);
    logic [m3i_pkg::IN_W-1:0] v;
    for (int i = 0; i < 9; i++) v[i*m3i_pkg::ELEM_W +: m3i_pkg::ELEM_W] = e[i];
    return v;
  endfunction

  // Four shapes in ten are of transform scale, three of them with a strong diagonal;
  // the rest are full range, tiny, corners or mixed, one singular by a repeated row.
  function automatic logic [m3i_pkg::IN_W-1:0] rand_matrix();
    m3i_pkg::elem_t e[9];
    int             shape;
    shape = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) begin
      case (shape)
        0, 1, 2, 3: e[i] = rand_elem(1);
        4:          e[i] = rand_elem(0);
        5:          e[i] = rand_elem(2);
        6:          e[i] = rand_elem(3);
        default:    e[i] = rand_elem($urandom_range(0, 3));
      endcase
    end
    if (shape < 3)
      for (int i = 0; i < 3; i++) e[i*4] = e[i*4] + 8 * ONE;
    if (shape == 7)
      for (int i = 0; i < 3; i++) e[6 + i] = e[i];
    return pack_matrix(e);
  endfunction

  task automatic send_matrix(input logic [m3i_pkg::IN_W-1:0] m);
    int n;
    if (!calm && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 13);
      in_tvalid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= m;
    do @(negedge clk); while (!in_taken);
  endtask

  initial begin
    m3i_pkg::elem_t d[9];
    int             waited;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    calm      = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed beats: identity, zero, corners, a scaled diagonal that saturates,
    // a tiny determinant that rounds to zero and a saturated determinant.
    d = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};             send_matrix(pack_matrix(d));
    d = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                   send_matrix(pack_matrix(d));
    for (int i = 0; i < 9; i++) d[i] = m3i_pkg::ELEM_MAX;
    send_matrix(pack_matrix(d));
    for (int i = 0; i < 9; i++) d[i] = m3i_pkg::ELEM_MIN;
    send_matrix(pack_matrix(d));
    for (int i = 0; i < 9; i++) d[i] = -1;              send_matrix(pack_matrix(d));
    d = '{m3i_pkg::ELEM_MAX, 0, 0, 0, m3i_pkg::ELEM_MAX, 0, 0, 0, m3i_pkg::ELEM_MAX};
    send_matrix(pack_matrix(d));
    d = '{m3i_pkg::ELEM_MIN, 0, 0, 0, m3i_pkg::ELEM_MIN, 0, 0, 0, m3i_pkg::ELEM_MIN};
    send_matrix(pack_matrix(d));
    d = '{m3i_pkg::ELEM_MIN, m3i_pkg::ELEM_MAX, 0, m3i_pkg::ELEM_MAX, m3i_pkg::ELEM_MIN,
          0, 0, 0, m3i_pkg::ELEM_MIN};
    send_matrix(pack_matrix(d));
    d = '{1, 0, 0, 0, 1, 0, 0, 0, 1};                   send_matrix(pack_matrix(d));
    d = '{256, 0, 0, 0, 256, 0, 0, 0, 256};             send_matrix(pack_matrix(d));
    d = '{ONE / 2, 0, 0, 0, ONE / 2, 0, 0, 0, ONE / 2}; send_matrix(pack_matrix(d));
    d = '{2 * ONE, 0, 0, 0, 3 * ONE, 0, 0, 0, -ONE};    send_matrix(pack_matrix(d));
    d = '{0, ONE, 0, ONE, 0, 0, 0, 0, ONE};             send_matrix(pack_matrix(d));
    d = '{ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE, 7 * ONE, 8 * ONE, 9 * ONE};
    send_matrix(pack_matrix(d));
    d = '{3 * ONE, 0, 2 * ONE, 2 * ONE, 0, -2 * ONE, 0, ONE, ONE};
    send_matrix(pack_matrix(d));
    d = '{m3i_pkg::ELEM_MAX, m3i_pkg::ELEM_MIN, m3i_pkg::ELEM_MAX,
          m3i_pkg::ELEM_MIN, m3i_pkg::ELEM_MAX, m3i_pkg::ELEM_MIN,
          m3i_pkg::ELEM_MAX, m3i_pkg::ELEM_MIN, m3i_pkg::ELEM_MAX};
    send_matrix(pack_matrix(d));
    d = '{ONE * 1000, 1, 0, 0, ONE * 1000, 0, 0, 0, ONE * 1000};
    send_matrix(pack_matrix(d));

    for (int k = 0; k < NUM_RANDOM; k++) begin
      if (k == NUM_RANDOM - CALM_TAIL) calm <= 1'b1;
      send_matrix(rand_matrix());
    end
    in_tvalid <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    repeat (60) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

/* matrix3_inverse_top.f */
design/m3i_pkg.sv
design/m3i_div_lane.sv
design/matrix3_inverse_top.sv
tb/matrix3_inverse_checker.sv
tb/matrix3_inverse_top_tb.sv
